@@ rtl/fupa_pkg.sv @@
// fupa_pkg: shared types, codes and helpers of the fixed unit pool allocator
// no dependencies; used by fupa_cell and fixed_unit_pool_allocator_unit
`default_nettype none

package fupa_pkg;

    // what a recency cell does on the next clock
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LEFT,
        CELL_RIGHT,
        CELL_LOAD
    } t_cell_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_FREED     = 2'd1,
        ST_NO_BLOCKS = 2'd2,
        ST_IGNORED   = 2'd3
    } t_status;

    // configuration register indexes
    localparam logic CFG_UNITS_PER_BLOCK = 1'b0;
    localparam logic CFG_UNIT_BYTES      = 1'b1;

    localparam int CFG_WIDTH  = 13;
    localparam int SIZE_WIDTH = 14;

    // unit size rounded to 2, 4 or a multiple of 4
    function automatic logic [SIZE_WIDTH-1:0] round_size(input logic [CFG_WIDTH-1:0] req);
        logic [SIZE_WIDTH-1:0] sum;
        begin
            sum = {1'b0, req} + SIZE_WIDTH'(3);
            if (req <= CFG_WIDTH'(2)) begin
                round_size = SIZE_WIDTH'(2);
            end else if (req <= CFG_WIDTH'(4)) begin
                round_size = SIZE_WIDTH'(4);
            end else begin
                round_size = {sum[SIZE_WIDTH-1:2], 2'b00};
            end
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/fupa_cell.sv @@
// fupa_cell: one place of the recency order, holding one open block's header
// depends on fupa_pkg for the cell operation codes
`default_nettype none

module fupa_cell #(
    parameter int EW = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire fupa_pkg::t_cell_op i_op,
    input  wire logic [EW-1:0]    i_left,
    input  wire logic [EW-1:0]    i_right,
    input  wire logic [EW-1:0]    i_load,
    output logic      [EW-1:0]    o_entry
);
    import fupa_pkg::*;

    logic          r_vld;
    logic [EW-2:0] r_data;

    // valid bit is control state and is cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            unique case (i_op)
                CELL_HOLD:  r_vld <= r_vld;
                CELL_LEFT:  r_vld <= i_left[EW-1];
                CELL_RIGHT: r_vld <= i_right[EW-1];
                CELL_LOAD:  r_vld <= i_load[EW-1];
                default:    r_vld <= r_vld;
            endcase
        end
    end

    // block header payload moves with its valid bit
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            CELL_HOLD:  r_data <= r_data;
            CELL_LEFT:  r_data <= i_left[EW-2:0];
            CELL_RIGHT: r_data <= i_right[EW-2:0];
            CELL_LOAD:  r_data <= i_load[EW-2:0];
            default:    r_data <= r_data;
        endcase
    end

    assign o_entry = {r_vld, r_data};

endmodule

`default_nettype wire

@@ rtl/fixed_unit_pool_allocator_unit.sv @@
// fixed_unit_pool_allocator_unit: top level, sequencer, link memory, cell chain
// depends on fupa_pkg and fupa_cell
// sequence: a free passes the look state before its result is valid; allocate from an open
//   block passes look and pop (link memory read); allocate that opens a block passes look
//   and the link initialization sweep over n = units per block units, one unit a cycle
// throughput: one transaction at a time; next input taken once the result leaves
// reset: synchronous active low; all slots unused, order empty, registers at defaults
`default_nettype none

module fixed_unit_pool_allocator_unit #(
    parameter int BLOCK_SLOTS = 8,
    parameter int MAX_UNITS   = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [12:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_action,
    input  wire logic [2:0]  i_free_slot,
    input  wire logic [7:0]  i_free_unit,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [2:0]       o_block_slot,
    output logic [7:0]       o_unit_index,
    output logic [19:0]      o_byte_offset,
    output logic             o_block_released
);
    import fupa_pkg::*;

    localparam int SW = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
    localparam int UW = $clog2(MAX_UNITS);
    localparam int CW = $clog2(MAX_UNITS + 1);
    localparam int EW = 1 + SW + UW + 2 * CW;
    localparam int MEM_DEPTH = BLOCK_SLOTS * (2 ** UW);
    localparam int AW = SW + UW;

    typedef struct packed {
        logic          vld;
        logic [SW-1:0] slot;
        logic [UW-1:0] first;
        logic [CW-1:0] cnt;
        logic [CW-1:0] units;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_POP,
        S_FILL,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration registers
    logic [8:0]  r_upb;
    logic [12:0] r_req_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upb       <= 9'd256;
            r_req_bytes <= 13'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_UNITS_PER_BLOCK: r_upb       <= i_cfg_wdata[8:0];
                CFG_UNIT_BYTES:      r_req_bytes <= i_cfg_wdata;
                default:             r_upb       <= r_upb;
            endcase
        end
    end

    // latched transaction
    logic       r_action;
    logic [2:0] r_fslot;
    logic [7:0] r_funit;

    logic [BLOCK_SLOTS-1:0] r_in_use;
    logic [SW-1:0]          r_pos;
    logic [CW-1:0]          r_fill;

    // link memory
    logic [UW-1:0] r_mem [MEM_DEPTH];
    logic [UW-1:0] r_rd_data;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [UW-1:0] w_wdata;
    logic [AW-1:0] w_raddr;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    // recency chain
    t_entry   w_ent [BLOCK_SLOTS];
    t_cell_op w_op  [BLOCK_SLOTS];
    t_entry   w_load;
    logic [BLOCK_SLOTS-1:0] w_vld_vec;

    for (genvar g = 0; g < BLOCK_SLOTS; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        if (g == 0) begin : g_head
            assign w_left = w_load;
        end else begin : g_mid
            assign w_left = w_ent[g-1];
        end
        if (g == BLOCK_SLOTS - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_ent[g+1];
        end
        fupa_cell #(.EW(EW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op[g]),
            .i_left  (w_left),
            .i_right (w_right),
            .i_load  (w_load),
            .o_entry (w_ent[g])
        );
        assign w_vld_vec[g] = w_ent[g].vld;
    end

    // effective unit count and rounded size
    logic [CW-1:0]         w_n;
    logic [SIZE_WIDTH-1:0] w_size;
    int                    n_int;

    always_comb begin
        n_int = int'(r_upb);
        if (n_int < 2) begin
            n_int = 2;
        end
        if (n_int > MAX_UNITS) begin
            n_int = MAX_UNITS;
        end
        w_n    = CW'(n_int);
        w_size = round_size(r_req_bytes);
    end

    // searches over the chain and free-slot vector
    logic          w_afound;
    logic [SW-1:0] w_apos;
    logic          w_mhit;
    logic [SW-1:0] w_mpos;
    logic [SW-1:0] w_fslot;
    logic          w_fslot_ok;
    logic [SW-1:0] w_free_s;
    logic          w_full;

    always_comb begin
        w_afound = 1'b0;
        w_apos   = '0;
        w_mhit   = 1'b0;
        w_mpos   = '0;
        w_free_s = '0;
        w_fslot  = SW'(r_fslot);
        w_fslot_ok = (int'(r_fslot) < BLOCK_SLOTS);
        for (int i = 0; i < BLOCK_SLOTS; i++) begin
            if (!w_afound && w_ent[i].vld && (w_ent[i].cnt != '0)) begin
                w_afound = 1'b1;
                w_apos   = SW'(i);
            end
            if (w_ent[i].vld && (w_ent[i].slot == w_fslot)) begin
                w_mhit = 1'b1;
                w_mpos = SW'(i);
            end
        end
        for (int i = BLOCK_SLOTS - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                w_free_s = SW'(i);
            end
        end
        w_full = w_ent[BLOCK_SLOTS-1].vld;
    end

    t_entry        w_a;
    t_entry        w_m;
    t_entry        w_p;
    logic          w_free_valid;
    logic [CW:0]   w_cnt_inc;
    logic          w_release;
    logic [CW:0]   w_fill_inc;
    logic [UW+SIZE_WIDTH-1:0] w_prod;

    assign w_a = w_ent[w_apos];
    assign w_m = w_ent[w_mpos];
    assign w_p = w_ent[r_pos];
    assign w_free_valid = w_fslot_ok && r_in_use[w_fslot] && w_mhit &&
                          (int'(r_funit) < int'(w_m.units));
    assign w_cnt_inc  = {1'b0, w_m.cnt} + (CW+1)'(1);
    assign w_release  = (w_cnt_inc >= {1'b0, w_m.units});
    assign w_fill_inc = {1'b0, r_fill} + (CW+1)'(1);
    assign w_prod     = w_p.first * w_size;

    // cell operations, memory accesses and the entry to load
    always_comb begin
        for (int i = 0; i < BLOCK_SLOTS; i++) begin
            w_op[i] = CELL_HOLD;
        end
        w_load  = w_m;
        w_we    = 1'b0;
        w_waddr = {w_fslot, UW'(r_funit)};
        w_wdata = w_m.first;
        w_raddr = {w_a.slot, w_a.first};
        unique case (r_state)
            S_LOOK: begin
                if (!r_action) begin
                    if (!w_afound && !w_full) begin
                        // open a new block at the front
                        for (int i = 0; i < BLOCK_SLOTS; i++) begin
                            w_op[i] = CELL_LEFT;
                        end
                        w_op[0]      = CELL_LOAD;
                        w_load.vld   = 1'b1;
                        w_load.slot  = w_free_s;
                        w_load.first = UW'(1);
                        w_load.cnt   = w_n - CW'(1);
                        w_load.units = w_n;
                    end
                end else if (w_free_valid) begin
                    // push unit onto the slot free list
                    w_we         = 1'b1;
                    w_load.first = UW'(r_funit);
                    w_load.cnt   = w_cnt_inc[CW-1:0];
                    if (w_release) begin
                        for (int i = 0; i < BLOCK_SLOTS; i++) begin
                            if (i >= int'(w_mpos)) begin
                                w_op[i] = CELL_RIGHT;
                            end
                        end
                    end else begin
                        for (int i = 1; i < BLOCK_SLOTS; i++) begin
                            if (i <= int'(w_mpos)) begin
                                w_op[i] = CELL_LEFT;
                            end
                        end
                        w_op[0] = CELL_LOAD;
                    end
                end
            end
            S_POP: begin
                // pop the head unit, link read came back this cycle
                w_load       = w_p;
                w_load.first = r_rd_data;
                w_load.cnt   = w_p.cnt - CW'(1);
                w_op[r_pos]  = CELL_LOAD;
            end
            S_FILL: begin
                // initial chain: unit i links to i+1, last unit to 0
                w_we    = 1'b1;
                w_waddr = {w_ent[0].slot, r_fill[UW-1:0]};
                w_wdata = (w_fill_inc < {1'b0, w_ent[0].units}) ?
                          w_fill_inc[UW-1:0] : '0;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // sequencer with registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_in_use         <= '0;
            o_out_valid      <= 1'b0;
            o_in_ready       <= 1'b0;
            o_status         <= '0;
            o_block_slot     <= '0;
            o_unit_index     <= '0;
            o_byte_offset    <= '0;
            o_block_released <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_action   <= i_action;
                        r_fslot    <= i_free_slot;
                        r_funit    <= i_free_unit;
                        o_in_ready <= 1'b0;
                        r_state    <= S_LOOK;
                    end else begin
                        o_in_ready <= 1'b1;
                    end
                end
                S_LOOK: begin
                    o_block_slot     <= '0;
                    o_unit_index     <= '0;
                    o_byte_offset    <= '0;
                    o_block_released <= r_action && w_free_valid && w_release;
                    if (!r_action) begin
                        if (w_afound) begin
                            r_pos   <= w_apos;
                            r_state <= S_POP;
                        end else if (!w_full) begin
                            r_in_use[w_free_s] <= 1'b1;
                            r_fill             <= '0;
                            r_state            <= S_FILL;
                        end else begin
                            o_status    <= ST_NO_BLOCKS;
                            o_out_valid <= 1'b1;
                            r_state     <= S_DONE;
                        end
                    end else begin
                        if (w_free_valid) begin
                            o_status <= ST_FREED;
                            if (w_release) begin
                                r_in_use[w_fslot] <= 1'b0;
                            end
                        end else begin
                            o_status <= ST_IGNORED;
                        end
                        o_out_valid <= 1'b1;
                        r_state     <= S_DONE;
                    end
                end
                S_POP: begin
                    o_status      <= ST_ALLOCATED;
                    o_block_slot  <= 3'(w_p.slot);
                    o_unit_index  <= 8'(w_p.first);
                    o_byte_offset <= w_prod[19:0];
                    o_out_valid   <= 1'b1;
                    r_state       <= S_DONE;
                end
                S_FILL: begin
                    r_fill <= w_fill_inc[CW-1:0];
                    if (w_fill_inc >= {1'b0, w_ent[0].units}) begin
                        o_status     <= ST_ALLOCATED;
                        o_block_slot <= 3'(w_ent[0].slot);
                        o_out_valid  <= 1'b1;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_out_ready) begin
                        o_out_valid <= 1'b0;
                        o_in_ready  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // open blocks sit contiguously at the front of the chain
    a_chain_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld_vec & (w_vld_vec + BLOCK_SLOTS'(1))) == '0)
        else $error("recency chain has a gap");

    // as many slots are in use as the chain holds open blocks
    a_use_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_in_use) == $countones(w_vld_vec))
        else $error("slot use and chain disagree");

    // input is taken only while no result is pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready with result pending");

    // a taken result makes the unit ready for the next transaction, with no result pending
    a_ready_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> (o_in_ready && !o_out_valid))
        else $error("no ready after result taken");

endmodule

`default_nettype wire
